// ----- hw/rtl/rti_pkg.sv -----
package rti_pkg;

  localparam int unsigned DetW  = 53;
  localparam int unsigned TnW   = 54;
  localparam int unsigned DivStages = 16;
  localparam int unsigned DivSteps  = 2;

  localparam logic [1:0] CFG_VERTEX_ONE   = 2'd0;
  localparam logic [1:0] CFG_VERTEX_TWO   = 2'd1;
  localparam logic [1:0] CFG_VERTEX_THREE = 2'd2;
  localparam logic [1:0] CFG_DET_EPSILON  = 2'd3;

  localparam logic [2:0] RSN_HIT      = 3'd0;
  localparam logic [2:0] RSN_PARALLEL = 3'd1;
  localparam logic [2:0] RSN_U_OUT    = 3'd2;
  localparam logic [2:0] RSN_V_OUT    = 3'd3;
  localparam logic [2:0] RSN_T_OUT    = 3'd4;

  typedef struct packed {
    logic signed [15:0] origin_x;
    logic signed [15:0] origin_y;
    logic signed [15:0] origin_z;
    logic signed [15:0] dir_x;
    logic signed [15:0] dir_y;
    logic signed [15:0] dir_z;
    logic [31:0]        best_t;
  } rti_in_t;

  typedef struct packed {
    logic        hit;
    logic [31:0] new_t;
    logic [2:0]  reject_reason;
  } rti_out_t;

  // Dot products handed from the geometry pipe to the classifier.
  typedef struct packed {
    logic signed [DetW-1:0] det;
    logic signed [DetW-1:0] un;
    logic signed [DetW-1:0] vn;
    logic signed [TnW-1:0]  tn;
    logic [31:0]            best;
  } rti_dot_t;

  // State of one quotient in flight through the divider.
  typedef struct packed {
    logic [2:0]      reason;
    logic            sat;
    logic [31:0]     best;
    logic [DetW-1:0] rem;
    logic [DetW-1:0] den;
    logic [31:0]     quo;
  } rti_div_t;

endpackage

// ----- hw/rtl/rti_geom.sv -----
module rti_geom import rti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [47:0] vertex_one_i,
  input  logic [47:0] vertex_two_i,
  input  logic [47:0] vertex_three_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  rti_in_t     data_i,
  output logic        valid_o,
  input  logic        stall_i,
  output rti_dot_t    data_o
);

  localparam int unsigned NumStages = 4;

  logic signed [15:0] va[3], vb[3], vc[3], org[3], dir[3];
  logic signed [16:0] e1[3], e2[3], tv[3];

  logic [NumStages-1:0] v_q, adv;

  // Stage 1: cross product terms.
  logic signed [15:0] dir1_q[3];
  logic signed [16:0] tv1_q[3];
  logic signed [32:0] pp_q[6];
  logic signed [33:0] qp_q[6];
  logic [31:0]        best1_q;
  // Stage 2: cross products.
  logic signed [15:0] dir2_q[3];
  logic signed [16:0] tv2_q[3];
  logic signed [33:0] pv_q[3];
  logic signed [34:0] qv_q[3];
  logic [31:0]        best2_q;
  // Stage 3: dot product terms.
  logic signed [50:0] de_q[3], du_q[3], dv_q[3];
  logic signed [51:0] dt_q[3];
  logic [31:0]        best3_q;
  // Stage 4: dot products.
  rti_dot_t           dot_q;

  always_comb begin
    org[0] = data_i.origin_x;
    org[1] = data_i.origin_y;
    org[2] = data_i.origin_z;
    dir[0] = data_i.dir_x;
    dir[1] = data_i.dir_y;
    dir[2] = data_i.dir_z;
    for (int i = 0; i < 3; i++) begin
      va[i] = signed'(vertex_one_i[16*i +: 16]);
      vb[i] = signed'(vertex_two_i[16*i +: 16]);
      vc[i] = signed'(vertex_three_i[16*i +: 16]);
      e1[i] = 17'(vb[i]) - 17'(va[i]);
      e2[i] = 17'(vc[i]) - 17'(va[i]);
      tv[i] = 17'(org[i]) - 17'(va[i]);
    end
  end

  // A stage moves when it is empty or the stage after it moves.
  always_comb begin
    adv[NumStages-1] = !v_q[NumStages-1] || !stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  assign stall_o = !adv[0];
  assign valid_o = v_q[NumStages-1];
  assign data_o  = dot_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) begin
      dir1_q  <= dir;
      tv1_q   <= tv;
      best1_q <= data_i.best_t;
      pp_q[0] <= 33'(dir[1]) * 33'(e2[2]);
      pp_q[1] <= 33'(dir[2]) * 33'(e2[1]);
      pp_q[2] <= 33'(dir[2]) * 33'(e2[0]);
      pp_q[3] <= 33'(dir[0]) * 33'(e2[2]);
      pp_q[4] <= 33'(dir[0]) * 33'(e2[1]);
      pp_q[5] <= 33'(dir[1]) * 33'(e2[0]);
      qp_q[0] <= 34'(tv[1]) * 34'(e1[2]);
      qp_q[1] <= 34'(tv[2]) * 34'(e1[1]);
      qp_q[2] <= 34'(tv[2]) * 34'(e1[0]);
      qp_q[3] <= 34'(tv[0]) * 34'(e1[2]);
      qp_q[4] <= 34'(tv[0]) * 34'(e1[1]);
      qp_q[5] <= 34'(tv[1]) * 34'(e1[0]);
    end
    if (adv[1]) begin
      dir2_q  <= dir1_q;
      tv2_q   <= tv1_q;
      best2_q <= best1_q;
      for (int i = 0; i < 3; i++) begin
        pv_q[i] <= 34'(pp_q[2*i]) - 34'(pp_q[2*i+1]);
        qv_q[i] <= 35'(qp_q[2*i]) - 35'(qp_q[2*i+1]);
      end
    end
    if (adv[2]) begin
      best3_q <= best2_q;
      for (int i = 0; i < 3; i++) begin
        de_q[i] <= 51'(e1[i]) * 51'(pv_q[i]);
        du_q[i] <= 51'(tv2_q[i]) * 51'(pv_q[i]);
        dv_q[i] <= 51'(dir2_q[i]) * 51'(qv_q[i]);
        dt_q[i] <= 52'(e2[i]) * 52'(qv_q[i]);
      end
    end
    if (adv[3]) begin
      dot_q.det  <= DetW'(de_q[0]) + DetW'(de_q[1]) + DetW'(de_q[2]);
      dot_q.un   <= DetW'(du_q[0]) + DetW'(du_q[1]) + DetW'(du_q[2]);
      dot_q.vn   <= DetW'(dv_q[0]) + DetW'(dv_q[1]) + DetW'(dv_q[2]);
      dot_q.tn   <= TnW'(dt_q[0]) + TnW'(dt_q[1]) + TnW'(dt_q[2]);
      dot_q.best <= best3_q;
    end
  end

endmodule

// ----- hw/rtl/rti_classify.sv -----
module rti_classify import rti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic [15:0] det_epsilon_i,
  input  logic        valid_i,
  output logic        stall_o,
  input  rti_dot_t    data_i,
  output logic        valid_o,
  input  logic        stall_i,
  output rti_div_t    data_o
);

  logic               v_q, adv;
  rti_div_t           div_q, div_d;
  logic [DetW-1:0]    mag;
  logic signed [54:0] unf, vnf, tnf, uv;
  logic               neg;

  // The sign of det is folded into the numerators so all tests are exact.
  always_comb begin
    neg  = data_i.det < 0;
    mag  = neg ? DetW'(-data_i.det) : DetW'(data_i.det);
    unf  = neg ? -55'(data_i.un) : 55'(data_i.un);
    vnf  = neg ? -55'(data_i.vn) : 55'(data_i.vn);
    tnf  = neg ? -55'(data_i.tn) : 55'(data_i.tn);
    uv   = unf + vnf;

    div_d.best = data_i.best;
    div_d.den  = mag;
    div_d.rem  = DetW'(tnf[54:16]);
    div_d.quo  = {tnf[15:0], 16'b0};
    div_d.sat  = {14'b0, tnf} >= {mag, 16'b0};
    priority if (data_i.det == 0 || mag < DetW'(det_epsilon_i)) begin
      div_d.reason = RSN_PARALLEL;
    end else if (unf < 0 || unf > 55'(mag)) begin
      div_d.reason = RSN_U_OUT;
    end else if (vnf < 0 || uv > 55'(mag)) begin
      div_d.reason = RSN_V_OUT;
    end else if (tnf < 0) begin
      div_d.reason = RSN_T_OUT;
    end else begin
      div_d.reason = RSN_HIT;
    end
  end

  assign adv     = !v_q || !stall_i;
  assign stall_o = !adv;
  assign valid_o = v_q;
  assign data_o  = div_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= 1'b0;
    end else if (adv) begin
      v_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) div_q <= div_d;
  end

endmodule

// ----- hw/rtl/rti_div.sv -----
module rti_div import rti_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  output logic     stall_o,
  input  rti_div_t data_i,
  output logic     valid_o,
  input  logic     stall_i,
  output rti_out_t data_o
);

  localparam int unsigned NumStages = DivStages + 1;

  logic [NumStages-1:0] v_q, adv;
  rti_div_t             st_q[DivStages];
  rti_out_t             out_q, out_d;
  logic [31:0]          tq;
  logic [2:0]           rsn;

  // Restoring division, a few quotient bits per stage. The dividend's low
  // bits ride in the quotient field and shift out as quotient bits shift in.
  function automatic rti_div_t div_steps(rti_div_t s);
    rti_div_t    o;
    logic [DetW:0] r_sh;
    o = s;
    for (int j = 0; j < DivSteps; j++) begin
      r_sh  = {o.rem, o.quo[31]};
      o.quo = {o.quo[30:0], 1'b0};
      if (r_sh >= {1'b0, o.den}) begin
        r_sh     = r_sh - {1'b0, o.den};
        o.quo[0] = 1'b1;
      end
      o.rem = r_sh[DetW-1:0];
    end
    return o;
  endfunction

  always_comb begin
    adv[NumStages-1] = !v_q[NumStages-1] || !stall_i;
    for (int k = NumStages - 2; k >= 0; k--) begin
      adv[k] = !v_q[k] || adv[k+1];
    end
  end

  always_comb begin
    tq  = st_q[DivStages-1].sat ? '1 : st_q[DivStages-1].quo;
    rsn = st_q[DivStages-1].reason;
    // An equal distance still counts as a hit.
    if (rsn == RSN_HIT && tq > st_q[DivStages-1].best) rsn = RSN_T_OUT;
    out_d.reject_reason = rsn;
    out_d.hit           = rsn == RSN_HIT;
    out_d.new_t         = (rsn == RSN_HIT) ? tq : st_q[DivStages-1].best;
  end

  assign stall_o = !adv[0];
  assign valid_o = v_q[NumStages-1];
  assign data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (adv[0]) v_q[0] <= valid_i;
      for (int k = 1; k < NumStages; k++) begin
        if (adv[k]) v_q[k] <= v_q[k-1];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv[0]) st_q[0] <= div_steps(data_i);
    for (int k = 1; k < DivStages; k++) begin
      if (adv[k]) st_q[k] <= div_steps(st_q[k-1]);
    end
    if (adv[NumStages-1]) out_q <= out_d;
  end

endmodule

// ----- hw/rtl/ray_triangle_intersect_top.sv -----
// Channel   Direction  Handshake                  Payload
// in        input      in_valid_i / in_stall_o    in_data_i (rti_in_t)
// out       output     out_valid_o / out_stall_i  out_data_o (rti_out_t)
// cfg       input      cfg_valid_i / cfg_ready_o  cfg_index_i, cfg_data_i
//
// One transaction is accepted per cycle while in_stall_o is low; it passes 22 register
// stages (4 geometry, 1 classify, 16 divider, 1 output) before its result is presented.
// The 32 quotient bits of t take 2 bits per divider stage.
// Reset clears all valid bits; vertices reset to zero, det_epsilon to 17.
// Empty stages keep filling while the output is stalled, so input stalls
// only once every stage holds a transaction.
module ray_triangle_intersect_top import rti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  rti_in_t     in_data_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output rti_out_t    out_data_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i
);

  logic [47:0] vertex_one_q, vertex_two_q, vertex_three_q;
  logic [15:0] det_epsilon_q;

  logic     g_valid, g_stall, c_valid, c_stall;
  rti_dot_t g_data;
  rti_div_t c_data;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vertex_one_q   <= '0;
      vertex_two_q   <= '0;
      vertex_three_q <= '0;
      det_epsilon_q  <= 16'd17;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (cfg_index_i)
        CFG_VERTEX_ONE:   vertex_one_q   <= cfg_data_i;
        CFG_VERTEX_TWO:   vertex_two_q   <= cfg_data_i;
        CFG_VERTEX_THREE: vertex_three_q <= cfg_data_i;
        CFG_DET_EPSILON:  det_epsilon_q  <= cfg_data_i[15:0];
        default:          ;
      endcase
    end
  end

  rti_geom u_geom (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .vertex_one_i   (vertex_one_q),
    .vertex_two_i   (vertex_two_q),
    .vertex_three_i (vertex_three_q),
    .valid_i        (in_valid_i),
    .stall_o        (in_stall_o),
    .data_i         (in_data_i),
    .valid_o        (g_valid),
    .stall_i        (g_stall),
    .data_o         (g_data)
  );

  rti_classify u_classify (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .det_epsilon_i (det_epsilon_q),
    .valid_i       (g_valid),
    .stall_o       (g_stall),
    .data_i        (g_data),
    .valid_o       (c_valid),
    .stall_i       (c_stall),
    .data_o        (c_data)
  );

  rti_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (c_valid),
    .stall_o (c_stall),
    .data_i  (c_data),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .data_o  (out_data_o)
  );

  // Input may only stall when the whole pipe is backed up behind the output.
  a_stall_backpressure: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i))
    else $error("input stalled without output backpressure");

  a_hit_reason: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.hit == (out_data_o.reject_reason == RSN_HIT)))
    else $error("hit flag disagrees with reason code");

  a_reason_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.reject_reason <= RSN_T_OUT))
    else $error("reason code out of range");

endmodule

// ----- dv/rti_checker.sv -----
`timescale 1ns / 100ps

module rti_checker import rti_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  input  logic        in_stall_i,
  input  rti_in_t     in_data_i,
  input  logic        out_valid_i,
  input  logic        out_stall_i,
  input  rti_out_t    out_data_i,
  input  logic        cfg_valid_i,
  input  logic        cfg_ready_i,
  input  logic [1:0]  cfg_index_i,
  input  logic [47:0] cfg_data_i,
  output int          errors_o,
  output int          pending_o,
  output int          results_o,
  output int          hits_o
);

  logic [47:0] tri_v1, tri_v2, tri_v3;
  logic [15:0] det_eps;
  rti_out_t    expected_hits[$];

  function automatic void unpack_vertex(input logic [47:0] v, output longint p[3]);
    p[0] = longint'(signed'(v[15:0]));
    p[1] = longint'(signed'(v[31:16]));
    p[2] = longint'(signed'(v[47:32]));
  endfunction

  function automatic void cross_prod(input longint a[3], input longint b[3],
                                     output longint r[3]);
    r[0] = a[1] * b[2] - a[2] * b[1];
    r[1] = a[2] * b[0] - a[0] * b[2];
    r[2] = a[0] * b[1] - a[1] * b[0];
  endfunction

  function automatic longint dot_prod(input longint a[3], input longint b[3]);
    return a[0] * b[0] + a[1] * b[1] + a[2] * b[2];
  endfunction

  // Truncated quotient in Q16.16, saturating once the integer part overflows.
  function automatic logic [31:0] t_quotient(input longint unsigned num,
                                             input longint unsigned den);
    longint unsigned q, r;
    q = num / den;
    r = num % den;
    if (q >= 64'h10000) return '1;
    for (int i = 0; i < 16; i++) begin
      r = r << 1;
      q = q << 1;
      if (r >= den) begin
        r = r - den;
        q = q | 1;
      end
    end
    return q[31:0];
  endfunction

  function automatic rti_out_t intersect_ray(input rti_in_t ray);
    longint a[3], b[3], c[3], e1[3], e2[3], org[3], dir[3], tv[3], pv[3], qv[3];
    longint det, mag, un, vn, tn;
    logic [31:0] tq;
    logic [2:0]  why;
    rti_out_t    res;
    unpack_vertex(tri_v1, a);
    unpack_vertex(tri_v2, b);
    unpack_vertex(tri_v3, c);
    org = '{longint'(ray.origin_x), longint'(ray.origin_y), longint'(ray.origin_z)};
    dir = '{longint'(ray.dir_x), longint'(ray.dir_y), longint'(ray.dir_z)};
    for (int i = 0; i < 3; i++) begin
      e1[i] = b[i] - a[i];
      e2[i] = c[i] - a[i];
      tv[i] = org[i] - a[i];
    end
    cross_prod(dir, e2, pv);
    det = dot_prod(e1, pv);
    mag = (det < 0) ? -det : det;
    tq  = '0;
    why = RSN_HIT;
    if (det == 0 || mag < longint'(det_eps)) begin
      why = RSN_PARALLEL;
    end else begin
      un = dot_prod(tv, pv);
      if (det < 0) un = -un;
      if (un < 0 || un > mag) begin
        why = RSN_U_OUT;
      end else begin
        cross_prod(tv, e1, qv);
        vn = dot_prod(dir, qv);
        if (det < 0) vn = -vn;
        if (vn < 0 || un + vn > mag) begin
          why = RSN_V_OUT;
        end else begin
          tn = dot_prod(e2, qv);
          if (det < 0) tn = -tn;
          if (tn < 0) begin
            why = RSN_T_OUT;
          end else begin
            tq = t_quotient(tn, mag);
            if (tq > ray.best_t) why = RSN_T_OUT;
          end
        end
      end
    end
    res.hit           = (why == RSN_HIT);
    res.new_t         = (why == RSN_HIT) ? tq : ray.best_t;
    res.reject_reason = why;
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("%0t: mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    errors_o++;
  endtask

  assign pending_o = expected_hits.size();

  always @(posedge clk_i or negedge rst_ni) begin
    rti_out_t want;
    if (!rst_ni) begin
      tri_v1    <= '0;
      tri_v2    <= '0;
      tri_v3    <= '0;
      det_eps   <= 16'd17;
      errors_o  = 0;
      results_o = 0;
      hits_o    = 0;
      expected_hits.delete();
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        unique case (cfg_index_i)
          CFG_VERTEX_ONE: begin
            tri_v1 <= cfg_data_i;
          end
          CFG_VERTEX_TWO: begin
            tri_v2 <= cfg_data_i;
          end
          CFG_VERTEX_THREE: begin
            tri_v3 <= cfg_data_i;
          end
          CFG_DET_EPSILON: begin
            det_eps <= cfg_data_i[15:0];
          end
        endcase
      end
      if (in_valid_i && !in_stall_i) expected_hits.push_back(intersect_ray(in_data_i));
      if (out_valid_i && !out_stall_i) begin
        results_o++;
        if (expected_hits.size() == 0) begin
          $display("%0t: result with no transaction outstanding", $realtime);
          errors_o++;
        end else begin
          want = expected_hits.pop_front();
          if (want.hit) hits_o++;
          if (out_data_i.hit != want.hit)
            report_mismatch("hit", 32'(out_data_i.hit), 32'(want.hit));
          if (out_data_i.new_t != want.new_t)
            report_mismatch("new_t", out_data_i.new_t, want.new_t);
          if (out_data_i.reject_reason != want.reject_reason)
            report_mismatch("reject_reason", 32'(out_data_i.reject_reason),
                            32'(want.reject_reason));
        end
      end
    end
  end

endmodule

// ----- dv/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
  import rti_pkg::*;

  localparam int StallLimit = 5000;
  localparam int DrainCycles = 40;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  rti_in_t     in_data = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  rti_out_t    out_data;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = CFG_VERTEX_ONE;
  logic [47:0] cfg_data = '0;
  int          errors, pending, results, hits;
  logic        no_gaps = 1'b0;
  int          quiet_cycles = 0;
  int          tri_a[3], tri_b[3], tri_c[3];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  ray_triangle_intersect_top dut (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_o(in_stall), .in_data_i(in_data),
    .out_valid_o(out_valid), .out_stall_i(out_stall), .out_data_o(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_o(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data)
  );

  rti_checker u_checker (
    .clk_i, .rst_ni,
    .in_valid_i(in_valid), .in_stall_i(in_stall), .in_data_i(in_data),
    .out_valid_i(out_valid), .out_stall_i(out_stall), .out_data_i(out_data),
    .cfg_valid_i(cfg_valid), .cfg_ready_i(cfg_ready),
    .cfg_index_i(cfg_index), .cfg_data_i(cfg_data),
    .errors_o(errors), .pending_o(pending), .results_o(results), .hits_o(hits)
  );

  always @(posedge clk_i) begin
    out_stall <= !no_gaps && ($urandom_range(99) < 33);
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
        quiet_cycles <= 0;
      else
        quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= StallLimit) begin
        $display("watchdog expired with %0d results outstanding", pending);
        $display("testbench: errors");
        $finish;
      end
    end
  end

  function automatic logic [15:0] clamp16(input int v);
    if (v > 32767) return 16'h7fff;
    if (v < -32768) return 16'h8000;
    return v[15:0];
  endfunction

  task automatic write_reg(input logic [1:0] idx, input logic [47:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk_i); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  task automatic load_triangle(input int a[3], input int b[3], input int c[3],
                               input logic [15:0] eps);
    tri_a = a;
    tri_b = b;
    tri_c = c;
    write_reg(CFG_VERTEX_ONE, {clamp16(a[2]), clamp16(a[1]), clamp16(a[0])});
    write_reg(CFG_VERTEX_TWO, {clamp16(b[2]), clamp16(b[1]), clamp16(b[0])});
    write_reg(CFG_VERTEX_THREE, {clamp16(c[2]), clamp16(c[1]), clamp16(c[0])});
    write_reg(CFG_DET_EPSILON, {32'd0, eps});
  endtask

  task automatic send_ray(input rti_in_t ray);
    in_data  <= ray;
    in_valid <= 1'b1;
    do @(posedge clk_i); while (in_stall);
    if (!no_gaps && $urandom_range(99) < 33) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  task automatic shoot(input int ox, oy, oz, dx, dy, dz, input logic [31:0] best);
    rti_in_t ray;
    ray = '{clamp16(ox), clamp16(oy), clamp16(oz), clamp16(dx), clamp16(dy),
            clamp16(dz), best};
    send_ray(ray);
  endtask

  // The block may still hold transactions in flight; let the pipe empty out.
  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  // Most rays aim at a point on or near the current triangle; the rest are noise.
  task automatic random_rays(input int count);
    int u, v, s, tgt[3], dir[3], lim;
    logic [31:0] best;
    rti_in_t ray;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 20) begin
        ray.origin_x = 16'($urandom);
        ray.origin_y = 16'($urandom);
        ray.origin_z = 16'($urandom);
        ray.dir_x = 16'($urandom);
        ray.dir_y = 16'($urandom);
        ray.dir_z = 16'($urandom);
        ray.best_t = $urandom;
        send_ray(ray);
      end else begin
        u = $urandom_range(300);
        v = $urandom_range(300 - u);
        s = $urandom_range(4);
        lim = ($urandom_range(3) == 0) ? 2000 : 300;
        for (int i = 0; i < 3; i++) begin
          tgt[i] = tri_a[i] + ((tri_b[i] - tri_a[i]) * u + (tri_c[i] - tri_a[i]) * v) / 256;
          dir[i] = $urandom_range(2 * lim) - lim;
        end
        case ($urandom_range(3))
          0: best = '1;
          1: best = $urandom;
          2: best = (s << 16) + $urandom_range(2) - 1;
          default: best = $urandom_range(32'h50000);
        endcase
        shoot(tgt[0] - dir[0] * s, tgt[1] - dir[1] * s, tgt[2] - dir[2] * s,
              dir[0], dir[1], dir[2], best);
      end
    end
  endtask

  initial begin
    int unit_a[3], unit_b[3], unit_c[3], big_a[3], big_b[3], big_c[3], r1[3], r2[3], r3[3];
    unit_a = '{0, 0, 0};
    unit_b = '{256, 0, 0};
    unit_c = '{0, 256, 0};
    big_a = '{-32768, -32768, -32768};
    big_b = '{32767, -32768, -32768};
    big_c = '{-32768, 32767, 32767};
    tri_a = '{0, 0, 0};
    tri_b = '{0, 0, 0};
    tri_c = '{0, 0, 0};
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Out of reset every vertex is zero, so everything comes back parallel.
    random_rays(20);
    drain();

    load_triangle(unit_a, unit_b, unit_c, 16'd17);
    shoot(64, 64, -256, 0, 0, 256, '1);
    shoot(64, 64, -256, 0, 0, 256, 32'h10000);
    shoot(64, 64, -256, 0, 0, 256, 32'h0ffff);
    shoot(0, 64, -256, 0, 0, 256, '1);
    shoot(256, 0, -256, 0, 0, 256, '1);
    shoot(0, 0, -256, 0, 0, 256, '1);
    shoot(300, 0, -256, 0, 0, 256, '1);
    shoot(-10, 64, -256, 0, 0, 256, '1);
    shoot(64, -10, -256, 0, 0, 256, '1);
    shoot(200, 200, -256, 0, 0, 256, '1);
    shoot(64, 64, 256, 0, 0, 256, '1);
    shoot(64, 64, -256, 256, 0, 0, '1);
    shoot(64, 64, -32768, 0, 0, 1, '1);
    shoot(-32768, -32768, -32768, 32767, 32767, 32767, 32'h0);
    shoot(32767, 32767, 32767, -32768, -32768, -32768, '1);
    shoot(0, 0, 0, 0, 0, 0, 32'h0);
    random_rays(200);
    drain();

    no_gaps = 1'b1;
    load_triangle(big_a, big_b, big_c, 16'hffff);
    shoot(-32768, -32768, -32768, 1, 1, 1, '1);
    random_rays(200);
    drain();
    no_gaps = 1'b0;

    load_triangle(unit_a, unit_b, unit_c, 16'd0);
    shoot(64, 64, -256, 256, 0, 0, '1);
    shoot(64, 64, -256, 0, 0, 1, '1);
    random_rays(200);
    drain();

    for (int i = 0; i < 3; i++) begin
      r1[i] = $urandom_range(8000) - 4000;
      r2[i] = r1[i] + $urandom_range(4000) - 2000;
      r3[i] = r1[i] + $urandom_range(4000) - 2000;
    end
    load_triangle(r1, r2, r3, 16'($urandom));
    random_rays(230);
    drain();

    $display("covered %0d ray tests, %0d hits, over five triangle and threshold settings",
             results, hits);
    if (errors == 0) begin
      $display("testbench: clean");
    end else begin
      $display("%0d mismatches", errors);
      $display("testbench: errors");
    end
    $finish;
  end

endmodule
